@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the run motif extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop on every rising clk edge, skipped while rst is high.
`define NRME_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: %m");
// Check that cond at one edge implies effect at the next edge.
`define NRME_ASSERT_NEXT(label, cond, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (effect)) \
    else $error("assertion failed: %m");
`else
`define NRME_ASSERT(label, prop)
`define NRME_ASSERT_NEXT(label, cond, effect)
`endif

`endif

@@ hw/rtl/nrme_pkg.sv @@
// Shared widths, register indexes and item types of the run motif extractor.
package nrme_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int WEIGHT_W    = 16;
  localparam int PROD_W      = SAMPLE_W + WEIGHT_W + 1;
  localparam int POS_W       = 16;
  localparam int LEN_W       = 17;
  localparam int IDX_W       = 17;
  localparam int PEAK_W      = 17;
  localparam int SCORE_W     = 48;
  localparam int MINLEN_W    = 16;
  localparam int MINSCORE_W  = 47;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 47;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;
  localparam int MOTIF_W     = IDX_W + 2 * POS_W + PEAK_W + SCORE_W;
  localparam int OUT_DATA_W  = ((MOTIF_W + 7) / 8) * 8;

  localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET   = WEIGHT_W'(256);
  localparam logic [MINLEN_W-1:0]   MINLEN_RESET   = MINLEN_W'(3);
  localparam logic [MINSCORE_W-1:0] MINSCORE_RESET = MINSCORE_W'(655);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_WEIGHT = 2'd0,
    REG_MIN_LENGTH   = 2'd1,
    REG_MIN_SCORE    = 2'd2
  } cfg_reg_t;

  // One classified sample on its way from front to back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [PROD_W-1:0]   product;
    logic [POS_W-1:0]           pos;
    logic                       last;
  } item_t;

  // Packed result; first member is the highest bits.
  typedef struct packed {
    logic signed [SCORE_W-1:0] motif_score;
    logic [PEAK_W-1:0]         peak_pos;
    logic [POS_W-1:0]          end_pos;
    logic [POS_W-1:0]          start_pos;
    logic [IDX_W-1:0]          motif_index;
  } motif_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic push;
    logic pop;
  } fifo_stat_t;

endpackage

@@ hw/rtl/nrme_front.sv @@
// Front stage: takes samples, tracks position and forms the weighted product.
module nrme_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nrme_pkg::SAMPLE_W-1:0]     sample,
  input  logic                              last_sample,
  input  logic [nrme_pkg::WEIGHT_W-1:0]     score_weight,
  output logic                              out_valid,
  input  logic                              out_ready,
  output nrme_pkg::item_t                   out_item
);

  logic [nrme_pkg::POS_W-1:0]         position;
  logic                               stage_valid;
  nrme_pkg::item_t                    stage;
  logic                               accept;
  logic signed [nrme_pkg::PROD_W-1:0] mul_a;
  logic signed [nrme_pkg::PROD_W-1:0] mul_b;

  assign in_ready = !stage_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign mul_a = {{(nrme_pkg::PROD_W - nrme_pkg::SAMPLE_W){sample[nrme_pkg::SAMPLE_W-1]}},
                  sample};
  assign mul_b = {{(nrme_pkg::PROD_W - nrme_pkg::WEIGHT_W){1'b0}}, score_weight};

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
        position    <= last_sample ? '0 : position + 1'b1;
      end else if (out_ready) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.sample  <= sample;
      stage.product <= mul_a * mul_b;
      stage.pos     <= position;
      stage.last    <= last_sample;
    end
  end

  assign out_valid = stage_valid;
  assign out_item  = stage;

endmodule

@@ hw/rtl/nrme_fifo.sv @@
// Short queue between front and back stages.
module nrme_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nrme_pkg::item_t      in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nrme_pkg::item_t      out_item,
  output nrme_pkg::fifo_stat_t stat
);

  nrme_pkg::item_t                  entries [nrme_pkg::FIFO_DEPTH];
  logic [nrme_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [nrme_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [nrme_pkg::FIFO_CNT_W-1:0]  count;
  logic                             full;
  logic                             empty;
  logic                             push;
  logic                             pop;

  assign full      = count == nrme_pkg::FIFO_CNT_W'(nrme_pkg::FIFO_DEPTH);
  assign empty     = count == '0;
  assign in_ready  = !full;
  assign out_valid = !empty;
  assign push      = in_valid && !full;
  assign pop       = out_ready && !empty;
  assign out_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_item;
  end

  assign stat.full  = full;
  assign stat.empty = empty;
  assign stat.push  = push;
  assign stat.pop   = pop;

endmodule

@@ hw/rtl/nrme_back.sv @@
// Back stage: run tracking, saturating score, acceptance test and result register.
module nrme_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  nrme_pkg::item_t                 in_item,
  input  logic [nrme_pkg::MINLEN_W-1:0]   min_length,
  input  logic [nrme_pkg::MINSCORE_W-1:0] min_score,
  output logic                            out_valid,
  input  logic                            out_ready,
  output nrme_pkg::motif_t                out_motif
);

  localparam logic signed [nrme_pkg::SCORE_W-1:0] SCORE_MAX =
    {1'b0, {(nrme_pkg::SCORE_W-1){1'b1}}};
  localparam logic signed [nrme_pkg::SCORE_W-1:0] SCORE_MIN =
    {1'b1, {(nrme_pkg::SCORE_W-1){1'b0}}};

  logic                                 in_run;
  logic [nrme_pkg::POS_W-1:0]           run_start;
  logic [nrme_pkg::LEN_W-1:0]           run_length;
  logic signed [nrme_pkg::SCORE_W-1:0]  score_sum;
  logic signed [nrme_pkg::SAMPLE_W-1:0] peak_value;
  logic [nrme_pkg::PEAK_W-1:0]          peak_position;
  logic [nrme_pkg::IDX_W-1:0]           motif_count;
  logic                                 res_valid;
  nrme_pkg::motif_t                     res;

  logic                                 in_run_next;
  logic [nrme_pkg::POS_W-1:0]           run_start_next;
  logic [nrme_pkg::LEN_W-1:0]           run_length_next;
  logic signed [nrme_pkg::SCORE_W-1:0]  score_sum_next;
  logic signed [nrme_pkg::SAMPLE_W-1:0] peak_value_next;
  logic [nrme_pkg::PEAK_W-1:0]          peak_position_next;
  logic [nrme_pkg::IDX_W-1:0]           motif_count_next;
  logic                                 res_valid_next;
  nrme_pkg::motif_t                     res_next;

  logic                                 take;
  logic                                 nonzero;
  logic                                 starting;
  logic signed [nrme_pkg::SCORE_W-1:0]  base_sum;
  logic signed [nrme_pkg::SAMPLE_W-1:0] base_peak;
  logic [nrme_pkg::LEN_W-1:0]           base_len;
  logic signed [nrme_pkg::SCORE_W:0]    sum_wide;
  logic signed [nrme_pkg::SCORE_W-1:0]  sum_sat;
  logic                                 finish;
  logic [nrme_pkg::LEN_W-1:0]           fin_len;
  logic signed [nrme_pkg::SCORE_W-1:0]  fin_sum;
  logic [nrme_pkg::POS_W-1:0]           fin_end;
  logic                                 emit;

  assign in_ready = !res_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign nonzero  = in_item.sample != '0;
  assign starting = !in_run;

  assign base_sum  = starting ? '0 : score_sum;
  assign base_peak = starting ? '0 : peak_value;
  assign base_len  = starting ? '0 : run_length;

  assign sum_wide = {base_sum[nrme_pkg::SCORE_W-1], base_sum}
                  + {{(nrme_pkg::SCORE_W + 1 - nrme_pkg::PROD_W)
                      {in_item.product[nrme_pkg::PROD_W-1]}}, in_item.product};

  always_comb begin
    if (sum_wide[nrme_pkg::SCORE_W] != sum_wide[nrme_pkg::SCORE_W-1]) begin
      sum_sat = sum_wide[nrme_pkg::SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end else begin
      sum_sat = sum_wide[nrme_pkg::SCORE_W-1:0];
    end
  end

  always_comb begin
    in_run_next        = in_run;
    run_start_next     = run_start;
    run_length_next    = run_length;
    score_sum_next     = score_sum;
    peak_value_next    = peak_value;
    peak_position_next = peak_position;
    motif_count_next   = motif_count;
    finish             = 1'b0;
    fin_len            = run_length;
    fin_sum            = score_sum;
    fin_end            = in_item.pos - 1'b1;

    if (nonzero) begin
      in_run_next     = 1'b1;
      score_sum_next  = sum_sat;
      run_length_next = (&base_len) ? base_len : base_len + 1'b1;
      if (starting) begin
        run_start_next     = in_item.pos;
        peak_value_next    = '0;
        peak_position_next = {1'b0, in_item.pos};
      end
      if (in_item.sample > base_peak) begin
        peak_value_next    = in_item.sample;
        peak_position_next = {1'b0, in_item.pos} + 1'b1;
      end
      fin_len = run_length_next;
      fin_sum = score_sum_next;
      fin_end = in_item.pos;
      finish  = in_item.last;
    end else begin
      finish = in_run;
    end

    emit = finish
        && (fin_len > {1'b0, min_length})
        && (fin_sum > $signed({1'b0, min_score}));

    res_next.motif_index = motif_count;
    res_next.start_pos   = run_start_next;
    res_next.end_pos     = fin_end;
    res_next.peak_pos    = peak_position_next;
    res_next.motif_score = fin_sum;

    if (emit) motif_count_next = motif_count + 1'b1;
    if (finish) in_run_next = 1'b0;
    if (in_item.last) begin
      in_run_next      = 1'b0;
      motif_count_next = nrme_pkg::IDX_W'(1);
    end

    if (take) begin
      res_valid_next = emit;
    end else if (out_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run        <= 1'b0;
      run_start     <= '0;
      run_length    <= '0;
      score_sum     <= '0;
      peak_value    <= '0;
      peak_position <= '0;
      motif_count   <= nrme_pkg::IDX_W'(1);
      res_valid     <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
      if (take) begin
        in_run        <= in_run_next;
        run_start     <= run_start_next;
        run_length    <= run_length_next;
        score_sum     <= score_sum_next;
        peak_value    <= peak_value_next;
        peak_position <= peak_position_next;
        motif_count   <= motif_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) res <= res_next;
  end

  assign out_valid = res_valid;
  assign out_motif = res;

endmodule

@@ hw/rtl/nonzero_run_motif_extractor.sv @@
// Top level of the non-zero run motif extractor: config registers, front, queue, back.
//
// Usage:
//   Samples arrive on the s_ channel, one signed Q8.8 value per beat in s_tdata,
//   with s_tlast high on the final sample of a profile. Each run of non-zero
//   samples that is longer than min_length and scores above min_score yields
//   one beat on the m_ channel: index, start, end, peak position and score.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_data while
//   the block is idle; unused indexes are ignored.
// Timing:
//   One sample per cycle sustained while m_tready stays high. m_tvalid rises once
//   the beat closing its run has passed, in order, the front product register,
//   the queue and the back result register.
//   The front multiply and the back 48-bit saturating add with its compare set
//   the cycle.
// Reset and stall:
//   rst (synchronous) restores default config, clears the queue and run state
//   and sets the motif number to one. When m_tready is low the result register
//   holds, the back stops, the four-entry queue fills, and only then does
//   s_tready fall.
`include "assert_macros.svh"

module nonzero_run_motif_extractor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [nrme_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample
  input  logic                              s_tlast,   // last_sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [16:0] motif_index, [32:17] start_pos, [48:33] end_pos,
  // [65:49] peak_pos, [113:66] motif_score, [119:114] zero
  output logic [nrme_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_wr_en,
  input  logic [nrme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nrme_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [nrme_pkg::WEIGHT_W-1:0]   score_weight;
  logic [nrme_pkg::MINLEN_W-1:0]   min_length;
  logic [nrme_pkg::MINSCORE_W-1:0] min_score;

  logic                 front_valid;
  logic                 front_ready;
  nrme_pkg::item_t      front_item;
  logic                 queue_valid;
  logic                 queue_ready;
  nrme_pkg::item_t      queue_item;
  nrme_pkg::fifo_stat_t queue_stat;
  nrme_pkg::motif_t     motif;

  // Config writes: decode index, drop anything outside the register list.
  always_ff @(posedge clk) begin
    if (rst) begin
      score_weight <= nrme_pkg::WEIGHT_RESET;
      min_length   <= nrme_pkg::MINLEN_RESET;
      min_score    <= nrme_pkg::MINSCORE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nrme_pkg::REG_SCORE_WEIGHT: score_weight <= cfg_data[nrme_pkg::WEIGHT_W-1:0];
        nrme_pkg::REG_MIN_LENGTH:   min_length   <= cfg_data[nrme_pkg::MINLEN_W-1:0];
        nrme_pkg::REG_MIN_SCORE:    min_score    <= cfg_data[nrme_pkg::MINSCORE_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept beats, stamp position, register sample times weight.
  nrme_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .sample       (s_tdata),
    .last_sample  (s_tlast),
    .score_weight (score_weight),
    .out_valid    (front_valid),
    .out_ready    (front_ready),
    .out_item     (front_item)
  );

  // Queue: decouple front from back so each stalls on its own.
  nrme_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_item  (queue_item),
    .stat      (queue_stat)
  );

  // Back: track runs, accumulate score, test and register results.
  nrme_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (queue_valid),
    .in_ready   (queue_ready),
    .in_item    (queue_item),
    .min_length (min_length),
    .min_score  (min_score),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_motif  (motif)
  );

  assign m_tdata = {{(nrme_pkg::OUT_DATA_W - nrme_pkg::MOTIF_W){1'b0}}, motif};

  // Never write into a full queue, never read an empty one.
  `NRME_ASSERT(a_no_push_full, !(queue_stat.push && queue_stat.full))
  `NRME_ASSERT(a_no_pop_empty, !(queue_stat.pop && queue_stat.empty))
  // An accepted beat always lands in the front product register.
  `NRME_ASSERT_NEXT(a_front_loaded, s_tvalid && s_tready, front_valid)

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the non-zero run motif extractor: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module tb_top;

  // Quiet cycles allowed before the run is declared hung. The slowest correct case
  // is the long receiver hold plus idle bursts, so this limit is well above that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_ITEMS   = 310;

  // Index that maps to no register; the block must ignore writes to it.
  localparam logic [nrme_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint SCORE_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SCORE_BOTTOM = -SCORE_TOP - 64'sd1;

  // One input beat as queued for the driver.
  typedef struct packed {
    logic signed [nrme_pkg::SAMPLE_W-1:0] sample;
    logic                                 last;
  } sample_beat_t;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                s_tvalid  = 1'b0;
  logic                                s_tready;
  logic [nrme_pkg::SAMPLE_W-1:0]       s_tdata   = '0;   // [15:0] sample
  logic                                s_tlast   = 1'b0; // last_sample
  logic                                m_tvalid;
  logic                                m_tready  = 1'b0;
  // [16:0] motif_index, [32:17] start_pos, [48:33] end_pos,
  // [65:49] peak_pos, [113:66] motif_score, [119:114] zero
  logic [nrme_pkg::OUT_DATA_W-1:0]     m_tdata;
  logic                                cfg_wr_en = 1'b0;
  logic [nrme_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [nrme_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

  // Stimulus controls, changed by the sequence with nonblocking writes only.
  logic idle_en  = 1'b1;
  logic hold_arm = 1'b0;

  sample_beat_t       profile_q[$];   // beats waiting to be sent
  nrme_pkg::motif_t   motif_q[$];     // motifs predicted but not yet seen
  int                 fail_count = 0;

  // Predictor copy of the registers and of the run tracker.
  logic [nrme_pkg::WEIGHT_W-1:0]        weight_c    = nrme_pkg::WEIGHT_RESET;
  logic [nrme_pkg::MINLEN_W-1:0]        min_len_c   = nrme_pkg::MINLEN_RESET;
  logic [nrme_pkg::MINSCORE_W-1:0]      min_score_c = nrme_pkg::MINSCORE_RESET;
  logic [nrme_pkg::POS_W-1:0]           pos_r       = '0;
  logic                                 in_run_r    = 1'b0;
  logic [nrme_pkg::POS_W-1:0]           run_start_r = '0;
  logic [nrme_pkg::LEN_W-1:0]           run_len_r   = '0;
  longint                               score_r     = 0;
  logic signed [nrme_pkg::SAMPLE_W-1:0] peak_val_r  = '0;
  logic [nrme_pkg::PEAK_W-1:0]          peak_pos_r  = '0;
  logic [nrme_pkg::IDX_W-1:0]           motif_num_r = 17'd1;

  nonzero_run_motif_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Close the open run; queue a motif if it passes both thresholds.
  task automatic close_run(input logic [nrme_pkg::POS_W-1:0] end_at);
    nrme_pkg::motif_t m;
    if (in_run_r && run_len_r > {1'b0, min_len_c} &&
        score_r > longint'({17'b0, min_score_c})) begin
      m.motif_index = motif_num_r;
      m.start_pos   = run_start_r;
      m.end_pos     = end_at;
      m.peak_pos    = peak_pos_r;
      m.motif_score = score_r[nrme_pkg::SCORE_W-1:0];
      motif_q.push_back(m);
      motif_num_r = motif_num_r + 17'd1;
    end
    in_run_r = 1'b0;
  endtask

  // Advance the run tracker by one accepted sample.
  task automatic step_profile(input logic signed [nrme_pkg::SAMPLE_W-1:0] smp,
                              input logic lst);
    if (smp != 0) begin
      if (!in_run_r) begin
        in_run_r    = 1'b1;
        run_start_r = pos_r;
        run_len_r   = '0;
        score_r     = 0;
        peak_val_r  = '0;
        peak_pos_r  = {1'b0, pos_r};
      end
      score_r = score_r + longint'(smp) * longint'({48'b0, weight_c});
      if (score_r > SCORE_TOP) score_r = SCORE_TOP;
      if (score_r < SCORE_BOTTOM) score_r = SCORE_BOTTOM;
      // Strict compare keeps the first of equal peaks.
      if (smp > peak_val_r) begin
        peak_val_r = smp;
        peak_pos_r = {1'b0, pos_r} + 17'd1;
      end
      if (run_len_r != '1) run_len_r = run_len_r + 17'd1;
      // A non-zero final sample belongs to the run it closes.
      if (lst) close_run(pos_r);
    end else if (in_run_r) begin
      close_run(pos_r - 16'd1);
    end
    if (lst) begin
      pos_r       = '0;
      motif_num_r = 17'd1;
      in_run_r    = 1'b0;
    end else begin
      pos_r = pos_r + 16'd1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued beats, idle in random bursts, hold while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    int send_gap;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        step_profile(s_tdata, s_tlast);
        profile_q.delete(0);
      end
      if (s_tvalid && !s_tready) begin
        // hold the beat until it is taken
      end else if (send_gap != 0) begin
        send_gap = send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 6);
        s_tvalid <= 1'b0;
      end else if (profile_q.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= profile_q[0].sample;
        s_tlast  <= profile_q[0].last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Report one field mismatch; return 1 on mismatch.
  function automatic int field_bad(input string name,
                                   input logic [nrme_pkg::SCORE_W-1:0] want_v,
                                   input logic [nrme_pkg::SCORE_W-1:0] got_v);
    if (want_v === got_v) return 0;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check each motif beat, stall in bursts and once for a long stretch.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    nrme_pkg::motif_t got;
    nrme_pkg::motif_t want;
    int     ready_gap;
    int     hold_left;
    logic   hold_done;
    if (rst) begin
      m_tready <= 1'b0;
      ready_gap = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[nrme_pkg::MOTIF_W-1:0];
        if (motif_q.size() == 0) begin
          $display("%0t: unexpected motif, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = motif_q.pop_front();
          fail_count += field_bad("motif_index",
                                  nrme_pkg::SCORE_W'(want.motif_index),
                                  nrme_pkg::SCORE_W'(got.motif_index));
          fail_count += field_bad("start_pos",
                                  nrme_pkg::SCORE_W'(want.start_pos),
                                  nrme_pkg::SCORE_W'(got.start_pos));
          fail_count += field_bad("end_pos",
                                  nrme_pkg::SCORE_W'(want.end_pos),
                                  nrme_pkg::SCORE_W'(got.end_pos));
          fail_count += field_bad("peak_pos",
                                  nrme_pkg::SCORE_W'(want.peak_pos),
                                  nrme_pkg::SCORE_W'(got.peak_pos));
          fail_count += field_bad("motif_score", want.motif_score, got.motif_score);
        end
      end
      // The long hold lets the internal queue fill so the input side must stall.
      if (hold_arm && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else if (ready_gap != 0) begin
        ready_gap = ready_gap - 1;
        m_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        ready_gap = $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no beat accepted for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------

  task automatic push_beat(input int v, input int l);
    sample_beat_t b;
    b.sample = nrme_pkg::SAMPLE_W'(v);
    b.last   = l[0];
    profile_q.push_back(b);
  endtask

  // Write one register and mirror it in the predictor; only call while idle.
  task automatic write_reg(input logic [nrme_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nrme_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      nrme_pkg::REG_SCORE_WEIGHT: weight_c    = val[nrme_pkg::WEIGHT_W-1:0];
      nrme_pkg::REG_MIN_LENGTH:   min_len_c   = val[nrme_pkg::MINLEN_W-1:0];
      nrme_pkg::REG_MIN_SCORE:    min_score_c = val[nrme_pkg::MINSCORE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every beat is sent and every motif seen, then let the pipe empty
  // of beats that close no motif.
  task automatic wait_idle();
    while (profile_q.size() != 0 || s_tvalid || motif_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [nrme_pkg::SAMPLE_W-1:0] pick_sample();
    logic signed [nrme_pkg::SAMPLE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = nrme_pkg::SAMPLE_W'($urandom_range(1, 600));
      1: v = nrme_pkg::SAMPLE_W'(-$urandom_range(1, 600));
      2: v = nrme_pkg::SAMPLE_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = 16'sd1;
          default: v = -16'sd1;
        endcase
      end
    endcase
    if (v == 0) v = 16'sd1;
    return v;
  endfunction

  // Build one profile: mostly runs split by zeros with a proper ending,
  // sometimes raw noise with stray zeros and last flags.
  task automatic queue_profile(output int n);
    sample_beat_t beats[$];
    sample_beat_t b;
    int runs;
    int len;
    int zeros;
    if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(1, 20);
      for (int k = 0; k < len; k++) begin
        b.sample = ($urandom_range(0, 3) == 0) ? 16'sd0 : nrme_pkg::SAMPLE_W'($urandom);
        b.last   = ($urandom_range(0, 7) == 0);
        beats.push_back(b);
      end
    end else begin
      runs = $urandom_range(1, 4);
      for (int r = 0; r < runs; r++) begin
        zeros = (r == 0) ? $urandom_range(0, 1) : $urandom_range(1, 3);
        b.last = 1'b0;
        b.sample = '0;
        for (int k = 0; k < zeros; k++) beats.push_back(b);
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          b.sample = pick_sample();
          beats.push_back(b);
        end
      end
      b.sample = '0;
      case ($urandom_range(0, 2))
        0: beats[beats.size()-1].last = 1'b1;
        1: begin
          b.last = 1'b1;
          beats.push_back(b);
        end
        default: begin
          beats.push_back(b);
          b.last = 1'b1;
          beats.push_back(b);
        end
      endcase
    end
    foreach (beats[i]) profile_q.push_back(beats[i]);
    n = beats.size();
  endtask

  task automatic run_random(input int target);
    int made;
    int n;
    made = 0;
    while (made < target) begin
      queue_profile(n);
      made += n;
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed profiles at reset config: field extremes, run closed by zero,
    // negative run closed by a non-zero final sample, length equal to the limit,
    // tied peaks with a zero final sample, and a lone zero final sample.
    push_beat(0, 0);
    push_beat(32767, 0);
    push_beat(-32768, 0);
    push_beat(1, 0);
    push_beat(-1, 0);
    push_beat(256, 0);
    push_beat(0, 0);
    push_beat(-5, 0);
    push_beat(-5, 0);
    push_beat(-5, 0);
    push_beat(-5, 1);
    push_beat(100, 0);
    push_beat(100, 0);
    push_beat(100, 0);
    push_beat(0, 0);
    push_beat(1, 0);
    push_beat(1, 0);
    push_beat(1, 0);
    push_beat(1, 0);
    push_beat(0, 0);
    push_beat(7, 0);
    push_beat(9, 0);
    push_beat(9, 0);
    push_beat(3, 0);
    push_beat(0, 1);
    push_beat(0, 1);
    wait_idle();

    // Zero weight and the top thresholds: nothing may come out.
    write_reg(nrme_pkg::REG_SCORE_WEIGHT, 47'd0);
    write_reg(nrme_pkg::REG_MIN_LENGTH, 47'd65535);
    write_reg(nrme_pkg::REG_MIN_SCORE, 47'h7FFF_FFFF_FFFF);
    run_random(40);

    // Random profiles at the reset values, with idling on both sides.
    write_reg(nrme_pkg::REG_SCORE_WEIGHT, 47'd256);
    write_reg(nrme_pkg::REG_MIN_LENGTH, 47'd3);
    write_reg(nrme_pkg::REG_MIN_SCORE, 47'd655);
    run_random(RANDOM_ITEMS);

    // Loose thresholds so motifs are dense; arm the long receiver hold.
    write_reg(nrme_pkg::REG_SCORE_WEIGHT,
              nrme_pkg::CFG_DATA_W'($urandom_range(1, 65535)));
    write_reg(nrme_pkg::REG_MIN_LENGTH, 47'd0);
    write_reg(nrme_pkg::REG_MIN_SCORE, 47'd0);
    hold_arm <= 1'b1;
    run_random(RANDOM_ITEMS);

    // Full weight, random threshold; poke the unused index with junk.
    write_reg(nrme_pkg::REG_SCORE_WEIGHT, 47'd65535);
    write_reg(nrme_pkg::REG_MIN_LENGTH, 47'd1);
    write_reg(nrme_pkg::REG_MIN_SCORE,
              nrme_pkg::CFG_DATA_W'($urandom_range(0, 32'h3FFF_FFFF)));
    write_reg(REG_UNUSED, nrme_pkg::CFG_DATA_W'({$urandom, $urandom}));
    run_random(RANDOM_ITEMS);

    // Closing stretch with no idling.
    idle_en <= 1'b0;
    write_reg(nrme_pkg::REG_SCORE_WEIGHT,
              nrme_pkg::CFG_DATA_W'($urandom_range(1, 65535)));
    write_reg(nrme_pkg::REG_MIN_LENGTH,
              nrme_pkg::CFG_DATA_W'($urandom_range(0, 6)));
    write_reg(nrme_pkg::REG_MIN_SCORE,
              nrme_pkg::CFG_DATA_W'($urandom_range(0, 200000)));
    run_random(RANDOM_ITEMS);

    // Catch any stray beat after the last expected motif.
    repeat (10) @(posedge clk);
    if (motif_q.size() != 0) begin
      $display("%0t: %0d expected motifs never arrived", $time, motif_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/nrme_pkg.sv
hw/rtl/nrme_front.sv
hw/rtl/nrme_fifo.sv
hw/rtl/nrme_back.sv
hw/rtl/nonzero_run_motif_extractor.sv
bench/tb_top.sv
